// ===== hw/rtl/lkvc_pkg.sv =====
// Shared constants for the LRU key-value cache: field widths, request codes and defaults.
package lkvc_pkg;

	// Widths fixed by the request and configuration formats.
	localparam int KIND_W = 2;
	localparam int CFG_W  = 5;

	// Request codes carried on the input tuser.
	localparam logic [KIND_W-1:0] KIND_GET = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

	// Default sizes and the reset value of the capacity register.
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// An accepted transaction is registered in the input stage and then in the result register before its result shows.
// Throughput: one request per cycle while the response side is not stalled; each request is handled
// by a parallel key compare over all entries and a rank update in every entry.
// Reset: arst_n clears all valid bits, ranks, occupancy and both pipeline stages
// at once; the capacity register returns to 16. Key and value storage is not reset.
module lru_key_value_cache #(
	parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF,
	parameter int S_DATA_W   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
	parameter int M_DATA_W   = ((VALUE_BITS + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration: capacity_in_use.
	input  logic                        cfg_we,
	input  logic [lkvc_pkg::CFG_W-1:0]  cfg_wdata,
	// Request stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [S_DATA_W-1:0]         s_tdata,  // key, value (from bit 0 up)
	input  logic [lkvc_pkg::KIND_W-1:0] s_tuser,  // kind
	// Response stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [M_DATA_W-1:0]         m_tdata,  // read_value
	output logic                        m_tuser   // hit
);
	import lkvc_pkg::*;

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int CW = (OW > CFG_W) ? OW : CFG_W;

	// Capacity register.
	logic [CFG_W-1:0] capacity_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Input stage.
	logic                  valid_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  valid_s2;
	logic                  hit_s2;
	logic [VALUE_BITS-1:0] rdata_s2;
	logic                  advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= s_tuser;
			key_s1   <= s_tdata[KEY_BITS-1:0];
			value_s1 <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
		end
	end

	// Entry state.
	logic [ENTRIES-1:0]    valid_q;
	logic [RW-1:0]         rank_q  [ENTRIES];
	logic [KEY_BITS-1:0]   key_q   [ENTRIES];
	logic [VALUE_BITS-1:0] value_q [ENTRIES];
	logic [OW-1:0]         occ_q;

	// Next-state signals.
	logic [ENTRIES-1:0]    match;
	logic                  hit;
	logic [RW-1:0]         hit_rank;
	logic [VALUE_BITS-1:0] hit_value;
	logic [ENTRIES-1:0]    valid_rm;
	logic [RW-1:0]         rank_rm [ENTRIES];
	logic [OW-1:0]         occ_rm;
	logic [CW-1:0]         cap_eff;
	logic                  evict_en;
	logic [RW-1:0]         victim_rank;
	logic [ENTRIES-1:0]    valid_ev;
	logic [OW-1:0]         occ_ev;
	logic [RW-1:0]         ins_idx;
	logic [ENTRIES-1:0]    valid_n;
	logic [RW-1:0]         rank_n [ENTRIES];
	logic [OW-1:0]         occ_n;
	logic                  wr_en;
	logic                  is_get;
	logic                  is_put;
	logic                  is_del;

	assign is_get = (kind_s1 == KIND_GET);
	assign is_put = (kind_s1 == KIND_PUT);
	assign is_del = (kind_s1 == KIND_DEL);

	// Parallel key compare over all valid entries.
	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_s1);
			if (match[i]) begin
				hit_rank  = hit_rank | rank_q[i];
				hit_value = hit_value | value_q[i];
			end
		end
		hit = |match;
	end

	// Removal of a matching entry, used by put and delete.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			valid_rm[i] = valid_q[i] && !match[i];
			if (hit && valid_q[i] && (rank_q[i] > hit_rank)) begin
				rank_rm[i] = rank_q[i] - RW'(1);
			end else begin
				rank_rm[i] = rank_q[i];
			end
		end
		occ_rm = occ_q - OW'(hit);
	end

	// Eviction of the least-recent entry when the store is at capacity.
	always_comb begin
		if (CW'(capacity_q) > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = CW'(capacity_q);
		end
		evict_en    = (CW'(occ_rm) >= cap_eff) && (occ_rm != '0);
		victim_rank = RW'(occ_rm - OW'(1));
		for (int i = 0; i < ENTRIES; i++) begin
			valid_ev[i] = valid_rm[i] && !(evict_en && (rank_rm[i] == victim_rank));
		end
		occ_ev = occ_rm - OW'(evict_en);
	end

	// Lowest free slot after removal and eviction.
	always_comb begin
		ins_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_ev[i]) begin
				ins_idx = RW'(i);
			end
		end
	end

	// Select the next state by request kind.
	always_comb begin
		valid_n = valid_q;
		occ_n   = occ_q;
		wr_en   = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_n[i] = rank_q[i];
		end
		case (kind_s1)
			KIND_GET: begin
				if (hit) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (match[i]) begin
							rank_n[i] = '0;
						end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
							rank_n[i] = rank_q[i] + RW'(1);
						end
					end
				end
			end
			KIND_PUT: begin
				wr_en = 1'b1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (RW'(i) == ins_idx) begin
						valid_n[i] = 1'b1;
						rank_n[i]  = '0;
					end else begin
						valid_n[i] = valid_ev[i];
						rank_n[i]  = valid_ev[i] ? rank_rm[i] + RW'(1) : rank_rm[i];
					end
				end
				occ_n = occ_ev + OW'(1);
			end
			KIND_DEL: begin
				valid_n = valid_rm;
				occ_n   = occ_rm;
				for (int i = 0; i < ENTRIES; i++) begin
					rank_n[i] = rank_rm[i];
				end
			end
			default: begin
				valid_n = valid_q;
			end
		endcase
	end

	// Control state of the entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			valid_q <= valid_n;
			occ_q   <= occ_n;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_n[i];
			end
		end
	end

	// Key and value storage, written at the insertion slot on a put.
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			key_q[ins_idx]   <= key_s1;
			value_q[ins_idx] <= value_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2   <= hit && (is_get || is_put || is_del);
			rdata_s2 <= (is_get && hit) ? hit_value : '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = hit_s2;
	assign m_tdata  = M_DATA_W'(rdata_s2);

endmodule

// ===== hw/rtl/lkvc_checker.sv =====
// Port-level checks for the LRU key-value cache and their binding to the top level.
module lkvc_checker #(
	parameter int S_DATA_W = 64,
	parameter int M_DATA_W = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [S_DATA_W-1:0]         s_tdata,  // key, value (from bit 0 up)
	input logic [lkvc_pkg::KIND_W-1:0] s_tuser,  // kind
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [M_DATA_W-1:0]         m_tdata,  // read_value
	input logic                        m_tuser   // hit
);
	import lkvc_pkg::*;

	// A waiting request keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("request changed while waiting");

	// A stalled response keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("response changed while stalled");

	// A response without a hit carries a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("nonzero read value without a hit");

	// The request side stalls only behind a stalled response.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("request side stalled without output back-pressure");

	// An accepted transaction reaches the output when the consumer is ready.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
		else $error("accepted request produced no response");

endmodule

bind lru_key_value_cache lkvc_checker #(
	.S_DATA_W(S_DATA_W),
	.M_DATA_W(M_DATA_W)
) u_lkvc_checker (.*);
